// File: hdl/dmwbc_pkg.sv
// ----------------------------------------------------------------------------
// dmwbc_pkg
// Types and constants shared by the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

  localparam int NUM_LINES  = 8;
  localparam int LINE_BYTES = 16;
  localparam int ADDR_BITS  = 16;
  localparam int OFF_BITS   = $clog2(LINE_BYTES);
  localparam int IDX_BITS   = $clog2(NUM_LINES);
  localparam int TAG_BITS   = 9;
  localparam int LINE_W     = LINE_BYTES * 8;
  localparam int WORDS      = (1 << ADDR_BITS) / LINE_BYTES;
  localparam int WADDR_BITS = ADDR_BITS - OFF_BITS;
  localparam int MAX_OFF    = LINE_BYTES - 4;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  wdata0;
    logic [7:0]  wdata1;
    logic [7:0]  wdata2;
    logic [7:0]  wdata3;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic       error;
    logic [7:0] rdata0;
    logic [7:0] rdata1;
    logic [7:0] rdata2;
    logic [7:0] rdata3;
  } out_item_t;

  // backing memory port control
  typedef struct packed {
    logic                  we;
    logic [WADDR_BITS-1:0] waddr;
    logic [LINE_W-1:0]     wdata;
    logic [LINE_BYTES-1:0] wbe;
    logic [WADDR_BITS-1:0] raddr;
  } mem_ctl_t;

endpackage

// File: hdl/direct_mapped_writeback_cache.sv
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache
// Direct-mapped write-allocate write-back cache over a line-wide backing RAM.
// ----------------------------------------------------------------------------
// latency from input beat to result beat runs through LOOK and DONE for a load,
// error or unused kind, and through LOOK, FILL and DONE for a read or write, hit
// or miss alike (victim write and refill read share the backing RAM cycle). one
// item at a time: a beat is taken only in IDLE, which follows each result beat.
// after reset the backing RAM is cleared one line per cycle (WORDS = 4096
// lines) before the first beat is taken; tags and valid bits clear at once.
module direct_mapped_writeback_cache (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dmwbc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dmwbc_pkg::out_item_t out_data
);

  localparam int OB = dmwbc_pkg::OFF_BITS;
  localparam int IB = dmwbc_pkg::IDX_BITS;
  localparam int TB = dmwbc_pkg::TAG_BITS;
  localparam int LW = dmwbc_pkg::LINE_W;
  localparam int NL = dmwbc_pkg::NUM_LINES;
  localparam int WB = dmwbc_pkg::WADDR_BITS;
  localparam int ADDR_BITS_HI = dmwbc_pkg::ADDR_BITS - 1;

  dmwbc_pkg::state_t state_r, state_nxt;
  dmwbc_pkg::in_item_t item_r;
  dmwbc_pkg::out_item_t res_r, res_nxt;
  logic [WB:0] clr_r;

  logic [NL-1:0] valid_r, mod_r;
  logic [TB-1:0] tag_r [NL];
  logic          hit_r;

  dmwbc_pkg::mem_ctl_t mctl;
  logic [LW-1:0] bk_rdata, ln_rdata;
  logic          ln_we;
  logic [LW-1:0] ln_wdata;
  logic [IB-1:0] ln_raddr;

  logic [OB-1:0] off;
  logic [IB-1:0] idx;
  logic [TB-1:0] tag;
  logic          is_acc, bad_off, hit_now;
  logic [LW-1:0] line_src, line_new;

  always_comb begin
    off     = item_r.address[OB-1:0];
    idx     = item_r.address[OB +: IB];
    tag     = item_r.address[OB+IB +: TB];
    is_acc  = (item_r.kind == dmwbc_pkg::KIND_READ) ||
              (item_r.kind == dmwbc_pkg::KIND_WRITE);
    bad_off = off > OB'(dmwbc_pkg::MAX_OFF);
    hit_now = valid_r[idx] && (tag_r[idx] == tag);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dmwbc_pkg::ST_CLEAR: if (clr_r[WB]) state_nxt = dmwbc_pkg::ST_IDLE;
      dmwbc_pkg::ST_IDLE:  if (in_valid) begin
        state_nxt = dmwbc_pkg::ST_LOOK;
      end
      dmwbc_pkg::ST_LOOK: begin
        if (!is_acc || bad_off) state_nxt = dmwbc_pkg::ST_DONE;
        else if (hit_now)       state_nxt = dmwbc_pkg::ST_FILL;
        else                    state_nxt = dmwbc_pkg::ST_FILL;
      end
      dmwbc_pkg::ST_FILL:  state_nxt = dmwbc_pkg::ST_DONE;
      dmwbc_pkg::ST_DONE:  if (out_ready) state_nxt = dmwbc_pkg::ST_IDLE;
      default:             state_nxt = dmwbc_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready  = (state_r == dmwbc_pkg::ST_IDLE);
    out_valid = (state_r == dmwbc_pkg::ST_DONE);
    out_data  = res_r;
    mctl      = '0;
    mctl.raddr = item_r.address[ADDR_BITS_HI:OB];
    ln_raddr  = idx;
    ln_we     = 1'b0;
    res_nxt   = res_r;
    line_src  = hit_r ? ln_rdata : bk_rdata;
    line_new  = line_src;
    if (item_r.kind == dmwbc_pkg::KIND_WRITE) begin
      line_new[{off, 3'b000} +: 8]        = item_r.wdata0;
      line_new[{off + OB'(1), 3'b000} +: 8] = item_r.wdata1;
      line_new[{off + OB'(2), 3'b000} +: 8] = item_r.wdata2;
      line_new[{off + OB'(3), 3'b000} +: 8] = item_r.wdata3;
    end
    ln_wdata = line_new;
    unique case (state_r)
      dmwbc_pkg::ST_CLEAR: begin
        mctl.we    = !clr_r[WB];
        mctl.waddr = clr_r[WB-1:0];
        mctl.wbe   = '1;
      end
      dmwbc_pkg::ST_IDLE: begin
        mctl.raddr = in_data.address[ADDR_BITS_HI:OB];
        ln_raddr   = in_data.address[OB +: IB];
      end
      dmwbc_pkg::ST_LOOK: begin
        res_nxt = '0;
        if (item_r.kind == dmwbc_pkg::KIND_LOAD) begin
          mctl.we    = 1'b1;
          mctl.waddr = item_r.address[ADDR_BITS_HI:OB];
          mctl.wbe   = '0;
          mctl.wbe[off] = 1'b1;
          mctl.wdata = {(LW/8){item_r.wdata0}};
        end else if (is_acc && bad_off) begin
          res_nxt.error = 1'b1;
        end else if (is_acc && !hit_now && mod_r[idx]) begin
          // victim leaves while the refill read is issued this same cycle;
          // write wins on a same-address collision, read returns old data
          mctl.we    = 1'b1;
          mctl.waddr = {tag_r[idx], idx};
          mctl.wbe   = '1;
          mctl.wdata = ln_rdata;
        end
        res_nxt.hit = is_acc && !bad_off && hit_now;
      end
      dmwbc_pkg::ST_FILL: begin
        ln_we = 1'b1;
        res_nxt.rdata0 = line_new[{off, 3'b000} +: 8];
        res_nxt.rdata1 = line_new[{off + OB'(1), 3'b000} +: 8];
        res_nxt.rdata2 = line_new[{off + OB'(2), 3'b000} +: 8];
        res_nxt.rdata3 = line_new[{off + OB'(3), 3'b000} +: 8];
      end
      dmwbc_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmwbc_pkg::ST_CLEAR;
      clr_r   <= '0;
      valid_r <= '0;
      mod_r   <= '0;
      hit_r   <= 1'b0;
      for (int i = 0; i < NL; i++) tag_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == dmwbc_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == dmwbc_pkg::ST_LOOK) hit_r <= hit_now;
      if (state_r == dmwbc_pkg::ST_FILL) begin
        valid_r[idx] <= 1'b1;
        tag_r[idx]   <= tag;
        mod_r[idx]   <= (item_r.kind == dmwbc_pkg::KIND_WRITE) ||
                        (hit_r && mod_r[idx]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    res_r <= res_nxt;
  end

  dmwbc_backing u_backing (
    .clk   (clk),
    .ctl   (mctl),
    .rdata (bk_rdata)
  );

  dmwbc_lines u_lines (
    .clk   (clk),
    .we    (ln_we),
    .waddr (idx),
    .wdata (ln_wdata),
    .raddr (ln_raddr),
    .rdata (ln_rdata)
  );

endmodule

// File: hdl/dmwbc_backing.sv
// ----------------------------------------------------------------------------
// dmwbc_backing
// Line-wide backing memory with byte enables, registered read.
// ----------------------------------------------------------------------------
module dmwbc_backing (
  input  logic                                  clk,
  input  dmwbc_pkg::mem_ctl_t                   ctl,
  output logic [dmwbc_pkg::LINE_W-1:0]          rdata
);

  logic [dmwbc_pkg::LINE_W-1:0] mem [dmwbc_pkg::WORDS];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      for (int b = 0; b < dmwbc_pkg::LINE_BYTES; b++) begin
        if (ctl.wbe[b]) begin
          mem[ctl.waddr][b*8 +: 8] <= ctl.wdata[b*8 +: 8];
        end
      end
    end
    rdata <= mem[ctl.raddr];
  end

endmodule

// File: hdl/dmwbc_lines.sv
// ----------------------------------------------------------------------------
// dmwbc_lines
// Cache line data store, registered read.
// ----------------------------------------------------------------------------
module dmwbc_lines (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [dmwbc_pkg::IDX_BITS-1:0]        waddr,
  input  logic [dmwbc_pkg::LINE_W-1:0]          wdata,
  input  logic [dmwbc_pkg::IDX_BITS-1:0]        raddr,
  output logic [dmwbc_pkg::LINE_W-1:0]          rdata
);

  logic [dmwbc_pkg::LINE_W-1:0] mem [dmwbc_pkg::NUM_LINES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the direct-mapped write-back cache against a behavioral cache and
// byte memory kept in the bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  dmwbc_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  dmwbc_pkg::out_item_t out_data;

  direct_mapped_writeback_cache uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // bench copy of the cache state
  logic        cl_valid [dmwbc_pkg::NUM_LINES];
  logic        cl_dirty [dmwbc_pkg::NUM_LINES];
  logic [8:0]  cl_tag [dmwbc_pkg::NUM_LINES];
  logic [7:0]  cl_bytes [dmwbc_pkg::NUM_LINES][dmwbc_pkg::LINE_BYTES];
  logic [7:0]  mem_bytes [65536];

  dmwbc_pkg::out_item_t pending_results[$];
  int errors = 0;
  int hold_cycles = 0;
  int out_wait = 0;
  int out_draw = 0;
  bit idle_out = 1;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic dmwbc_pkg::out_item_t cache_access(dmwbc_pkg::in_item_t it);
    dmwbc_pkg::out_item_t r;
    logic [3:0] off;
    logic [2:0] idx;
    logic [8:0] tg;
    logic [15:0] vbase;
    r = '0;
    off = it.address[3:0];
    idx = it.address[6:4];
    tg = it.address[15:7];
    if (it.kind == dmwbc_pkg::KIND_LOAD) begin
      mem_bytes[it.address] = it.wdata0;
      return r;
    end
    if (it.kind == dmwbc_pkg::KIND_NONE) return r;
    if (off > dmwbc_pkg::MAX_OFF) begin
      r.error = 1'b1;
      return r;
    end
    if (cl_valid[idx] && cl_tag[idx] == tg) begin
      r.hit = 1'b1;
    end else begin
      if (cl_dirty[idx]) begin
        vbase = {cl_tag[idx], idx, 4'h0};
        for (int i = 0; i < dmwbc_pkg::LINE_BYTES; i++)
          mem_bytes[vbase + i] = cl_bytes[idx][i];
      end
      for (int i = 0; i < dmwbc_pkg::LINE_BYTES; i++)
        cl_bytes[idx][i] = mem_bytes[{it.address[15:4], 4'h0} + i];
      cl_valid[idx] = 1;
      cl_dirty[idx] = 0;
      cl_tag[idx] = tg;
    end
    if (it.kind == dmwbc_pkg::KIND_WRITE) begin
      cl_bytes[idx][off] = it.wdata0;
      cl_bytes[idx][off + 1] = it.wdata1;
      cl_bytes[idx][off + 2] = it.wdata2;
      cl_bytes[idx][off + 3] = it.wdata3;
      cl_dirty[idx] = 1;
    end
    r.rdata0 = cl_bytes[idx][off];
    r.rdata1 = cl_bytes[idx][off + 1];
    r.rdata2 = cl_bytes[idx][off + 2];
    r.rdata3 = cl_bytes[idx][off + 3];
    return r;
  endfunction

  task automatic send_item(logic [1:0] k, logic [15:0] a, logic [31:0] d);
    dmwbc_pkg::in_item_t it;
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.kind = k;
    it.address = a;
    {it.wdata0, it.wdata1, it.wdata2, it.wdata3} = d;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(cache_access(it));
  endtask

  // receiver side: random wait per beat, or a long hold when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      out_draw = idle_out ? $urandom_range(0, 7) : 0;
      out_wait <= out_draw;
      out_ready <= (out_draw == 0);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_ready <= (out_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        dmwbc_pkg::out_item_t e;
        e = pending_results.pop_front();
        if (out_data.hit !== e.hit || out_data.error !== e.error ||
            out_data.rdata0 !== e.rdata0 || out_data.rdata1 !== e.rdata1 ||
            out_data.rdata2 !== e.rdata2 || out_data.rdata3 !== e.rdata3) begin
          $display("%0t mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(dmwbc_pkg::KIND_LOAD, 16'h0000, 32'hA5000000);
    send_item(dmwbc_pkg::KIND_LOAD, 16'hFFFF, 32'hFF000000);
    send_item(dmwbc_pkg::KIND_LOAD, 16'h0083, 32'h5A000000);
    send_item(dmwbc_pkg::KIND_READ, 16'h0000, 32'h0);
    send_item(dmwbc_pkg::KIND_READ, 16'h0000, 32'h0);
    send_item(dmwbc_pkg::KIND_READ, 16'hFFFC, 32'h0);
    send_item(dmwbc_pkg::KIND_READ, 16'hFFFD, 32'h0);   // offset past line end
    send_item(dmwbc_pkg::KIND_WRITE, 16'h000F, 32'h11223344);
    send_item(dmwbc_pkg::KIND_WRITE, 16'h0004, 32'hFFFFFFFF);
    send_item(dmwbc_pkg::KIND_WRITE, 16'h0008, 32'h01020304); // repeated write hit
    send_item(dmwbc_pkg::KIND_READ, 16'h0080, 32'h0);    // evicts dirty line
    send_item(dmwbc_pkg::KIND_READ, 16'h0004, 32'h0);    // refill sees written data
    send_item(dmwbc_pkg::KIND_LOAD, 16'h0005, 32'h77000000); // load under cached line
    send_item(dmwbc_pkg::KIND_READ, 16'h0004, 32'h0);
    send_item(dmwbc_pkg::KIND_NONE, 16'hFFFF, 32'hFFFFFFFF);
    send_item(dmwbc_pkg::KIND_WRITE, 16'hFF8C, 32'hDEADBEEF);
    send_item(dmwbc_pkg::KIND_READ, 16'h000C, 32'h0);
    send_item(dmwbc_pkg::KIND_READ, 16'hFF8C, 32'h0);
  endtask

  task automatic test_back_pressure();
    hold_cycles = 200;
    for (int i = 0; i < 10; i++)
      send_item(2'($urandom_range(0, 1)),
                {9'($urandom_range(0, 3)), 3'(i), 4'h4}, $urandom);
    drain();
    idle_out = 0;
    for (int i = 0; i < 20; i++)
      send_item(dmwbc_pkg::KIND_READ,
                {9'($urandom), 3'($urandom_range(0, 7)), 4'h8}, 32'h0);
    drain();
    idle_out = 1;
  endtask

  task automatic test_random();
    logic [1:0] k;
    logic [15:0] a;
    for (int n = 0; n < 600; n++) begin
      case ($urandom_range(0, 19))
        0, 1: k = dmwbc_pkg::KIND_LOAD;
        2: k = dmwbc_pkg::KIND_NONE;
        3, 4, 5, 6, 7, 8, 9, 10: k = dmwbc_pkg::KIND_WRITE;
        default: k = dmwbc_pkg::KIND_READ;
      endcase
      a = 16'($urandom);
      // mostly a few tags so lines hit, evict and come back
      if ($urandom_range(0, 3) != 0) a[15:7] = 9'($urandom_range(0, 3) * 9'h0AB);
      if ($urandom_range(0, 7) != 0) a[3:0] = 4'($urandom_range(0, dmwbc_pkg::MAX_OFF));
      send_item(k, a, $urandom);
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    for (int i = 0; i < dmwbc_pkg::NUM_LINES; i++) begin
      cl_valid[i] = 0;
      cl_dirty[i] = 0;
      cl_tag[i] = '0;
      for (int j = 0; j < dmwbc_pkg::LINE_BYTES; j++) cl_bytes[i][j] = '0;
    end
    for (int i = 0; i < 65536; i++) mem_bytes[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_back_pressure();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end
endmodule
